FILE: hdl/serial_line_command_decoder_defines.svh
// ----------------------------------------------------------------------------
// Serial line command decoder assertion macros
// Shared assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_COMMAND_DECODER_DEFINES_SVH
`define SERIAL_LINE_COMMAND_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define SLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define SLD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/sld_pkg.sv
// ----------------------------------------------------------------------------
// Serial line command decoder package
// Command table, command codes and the status records passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

    localparam int CMD_COUNT  = 8;
    localparam int CMD_MAXLEN = 8;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 4;

    localparam logic [7:0]       LINE_END = 8'h0A;
    localparam logic [POS_W-1:0] POS_MAX  = 4'd15;
    localparam logic [7:0]       CR       = 8'h0D;
    localparam logic [7:0]       LF       = 8'h0A;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_ON     = 4'd1,
        CMD_OFF    = 4'd2,
        CMD_L1ON   = 4'd3,
        CMD_L1OFF  = 4'd4,
        CMD_L2ON   = 4'd5,
        CMD_L2OFF  = 4'd6,
        CMD_FANON  = 4'd7,
        CMD_FANOFF = 4'd8
    } t_cmd_code;

    localparam logic [0:CMD_COUNT-1][0:CMD_MAXLEN-1][7:0] CMD_TEXT = '{
        '{"O", "N", CR,  LF,  8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", CR,  LF,    8'h00, 8'h00, 8'h00},
        '{"L", "1", "O", "N", CR,    LF,    8'h00, 8'h00},
        '{"L", "1", "O", "F", "F",   CR,    LF,    8'h00},
        '{"L", "2", "O", "N", CR,    LF,    8'h00, 8'h00},
        '{"L", "2", "O", "F", "F",   CR,    LF,    8'h00},
        '{"F", "A", "N", "O", "N",   CR,    LF,    8'h00},
        '{"F", "A", "N", "O", "F",   "F",   CR,    LF}
    };

    localparam logic [0:CMD_COUNT-1][LEN_W-1:0] CMD_LEN = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd7, 4'd7, 4'd8
    };

    typedef struct packed {
        logic      line_end;
        t_cmd_code code;
    } t_match_res;

    typedef struct packed {
        logic [7:0] pattern;
        logic       power;
        logic       refused;
        logic       fan;
    } t_exec_res;

endpackage

`default_nettype wire

FILE: hdl/sld_match.sv
// ----------------------------------------------------------------------------
// Serial line command decoder matcher
// Narrows the candidate set per byte and picks the command at a line end.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_match import sld_pkg::*; (
    input  wire logic [7:0]           i_byte,
    input  wire logic [POS_W-1:0]     i_pos,
    input  wire logic [CMD_COUNT-1:0] i_mask,
    output logic      [POS_W-1:0]     o_pos_nxt,
    output logic      [CMD_COUNT-1:0] o_mask_nxt,
    output t_match_res                o_res
);

    logic [CMD_COUNT-1:0] w_hit;
    logic [CMD_COUNT-1:0] w_fit;
    logic [POS_W:0]       w_len_now;
    t_cmd_code            w_code;

    assign w_len_now = {1'b0, i_pos} + 5'd1;

    always_comb begin
        for (int c = 0; c < CMD_COUNT; c++) begin
            w_hit[c] = ({1'b0, i_pos} < {1'b0, CMD_LEN[c]}) &&
                       (CMD_TEXT[c][i_pos[2:0]] == i_byte);
            w_fit[c] = i_mask[c] && (w_len_now == {1'b0, CMD_LEN[c]});
        end
    end

    always_comb begin
        w_code = CMD_NONE;
        for (int c = CMD_COUNT - 1; c >= 0; c--) begin
            if (w_fit[c]) begin
                w_code = t_cmd_code'(4'(c + 1));
            end
        end
    end

    always_comb begin
        if (i_byte == LINE_END) begin
            o_pos_nxt  = '0;
            o_mask_nxt = '1;
            o_res      = '{line_end: 1'b1, code: w_code};
        end else begin
            o_pos_nxt  = (i_pos < POS_MAX) ? i_pos + 4'd1 : i_pos;
            o_mask_nxt = i_mask & w_hit;
            o_res      = '{line_end: 1'b0, code: CMD_NONE};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sld_exec.sv
// ----------------------------------------------------------------------------
// Serial line command decoder executor
// Applies a recognized command to the LED pattern and the power flag, and flags refusals and fan start.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_exec import sld_pkg::*; (
    input  wire t_match_res       i_res,
    input  wire logic [7:0]       i_pattern,
    input  wire logic             i_power,
    input  wire logic [7:0]       i_group_one,
    input  wire logic [7:0]       i_group_two,
    output t_exec_res             o_res
);

    always_comb begin
        o_res = '{pattern: i_pattern, power: i_power, refused: 1'b0, fan: 1'b0};
        case (i_res.code)
            CMD_ON: begin
                o_res.pattern = 8'hFF;
                o_res.power   = 1'b1;
            end
            CMD_OFF: begin
                o_res.pattern = 8'h00;
                o_res.power   = 1'b0;
            end
            CMD_L1ON: begin
                if (i_power) begin
                    o_res.pattern = i_group_one;
                end else begin
                    o_res.refused = 1'b1;
                end
            end
            CMD_L1OFF: begin
                o_res.pattern = i_pattern & ~i_group_one;
            end
            CMD_L2ON: begin
                if (i_power) begin
                    o_res.pattern = i_group_two;
                end else begin
                    o_res.refused = 1'b1;
                end
            end
            CMD_L2OFF: begin
                o_res.pattern = i_pattern & ~i_group_two;
            end
            CMD_FANON: begin
                o_res.fan = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/serial_line_command_decoder.sv
// ----------------------------------------------------------------------------
// Serial line command decoder
// Matches received byte lines against fixed commands and drives the LED port.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while results are accepted
// and returns one result per byte via the input register, then the matcher and
// executor into the result register. Matching state is updated in that single
// pass, so bytes stream back to back. While a result waits, one more byte is
// taken into the input register; further bytes are held off until the result
// is accepted. The user must write group masks through the configuration port
// only while no transaction is open; the block does not enforce this.
`default_nettype none

`include "serial_line_command_decoder_defines.svh"

module serial_line_command_decoder import sld_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_led_pattern,
    output logic            o_power_on,
    output logic            o_line_done,
    output logic [3:0]      o_command_code,
    output logic            o_refused_power_off,
    output logic            o_fan_start
);

    localparam logic CFG_GROUP_ONE = 1'b0;
    localparam logic CFG_GROUP_TWO = 1'b1;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic [POS_W-1:0]     r_pos;
    logic [CMD_COUNT-1:0] r_mask;
    logic [7:0]           r_pattern;
    logic                 r_power;
    logic [7:0]           r_group_one;
    logic [7:0]           r_group_two;
    logic                 r_out_valid;
    logic [7:0]           r_out_pattern;
    logic                 r_out_power;
    logic                 r_out_done;
    t_cmd_code            r_out_code;
    logic                 r_out_refused;
    logic                 r_out_fan;

    logic [POS_W-1:0]     n_pos;
    logic [CMD_COUNT-1:0] n_mask;
    t_match_res           w_match;
    t_exec_res            w_exec;
    logic                 w_advance;
    logic                 w_process;

    assign w_advance = !r_out_valid || i_ready;
    assign w_process = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;

    sld_match u_match (
        .i_byte     (r_in_byte),
        .i_pos      (r_pos),
        .i_mask     (r_mask),
        .o_pos_nxt  (n_pos),
        .o_mask_nxt (n_mask),
        .o_res      (w_match)
    );

    sld_exec u_exec (
        .i_res       (w_match),
        .i_pattern   (r_pattern),
        .i_power     (r_power),
        .i_group_one (r_group_one),
        .i_group_two (r_group_two),
        .o_res       (w_exec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_one <= 8'h55;
            r_group_two <= 8'hAA;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GROUP_ONE: r_group_one <= i_cfg_data;
                CFG_GROUP_TWO: r_group_two <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_mask      <= '1;
            r_pattern   <= 8'hFF;
            r_power     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_process) begin
            r_pos       <= n_pos;
            r_mask      <= n_mask;
            r_pattern   <= w_exec.pattern;
            r_power     <= w_exec.power;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_process) begin
            r_out_pattern <= w_exec.pattern;
            r_out_power   <= w_exec.power;
            r_out_done    <= w_match.line_end;
            r_out_code    <= w_match.code;
            r_out_refused <= w_exec.refused;
            r_out_fan     <= w_exec.fan;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_led_pattern       = r_out_pattern;
    assign o_power_on          = r_out_power;
    assign o_line_done         = r_out_done;
    assign o_command_code      = r_out_code;
    assign o_refused_power_off = r_out_refused;
    assign o_fan_start         = r_out_fan;

    `SLD_ASSERT_IMP(a_code_only_at_line_end, i_clk, i_rst_n,
        o_valid && !o_line_done, o_command_code == CMD_NONE)
    `SLD_ASSERT_IMP(a_refusal_needs_power_off, i_clk, i_rst_n, o_valid && o_refused_power_off,
        !o_power_on && (o_command_code == CMD_L1ON || o_command_code == CMD_L2ON))
    `SLD_ASSERT_IMP(a_fan_only_on_fanon, i_clk, i_rst_n,
        o_valid && o_fan_start, o_command_code == CMD_FANON)
    `SLD_ASSERT_NXT(a_line_end_restarts_match, i_clk, i_rst_n,
        w_process && r_in_byte == LINE_END, r_pos == '0 && r_mask == '1)

endmodule

`default_nettype wire

FILE: test/tb_serial_line_command_decoder.sv
// ----------------------------------------------------------------------------
// Serial line command decoder testbench
// Sends command lines, noise and broken lines through the byte channel under
// random idling. A scoreboard predicts every result and compares each field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_serial_line_command_decoder;
    import sld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       GROUP_ONE_REG = 1'b0;
    localparam logic       GROUP_TWO_REG = 1'b1;
    localparam logic [7:0] NEWLINE       = 8'h0A;
    localparam int         PHASE_BYTES   = 235;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [7:0] led;
        logic       power;
        logic       done;
        logic [3:0] code;
        logic       refused;
        logic       fan;
    } t_led_status;

    class t_led_scoreboard;
        logic [7:0]  group_one;
        logic [7:0]  group_two;
        logic [3:0]  position;
        logic [7:0]  candidates;
        logic [7:0]  pattern;
        logic        power;
        t_led_status expected_q[$];
        int          errors;

        function new();
            group_one  = 8'h55;
            group_two  = 8'hAA;
            position   = 4'd0;
            candidates = 8'hFF;
            pattern    = 8'hFF;
            power      = 1'b0;
            errors     = 0;
        endfunction

        static function string command_text(int c);
            case (c)
                0: return "ON\015\n";
                1: return "OFF\015\n";
                2: return "L1ON\015\n";
                3: return "L1OFF\015\n";
                4: return "L2ON\015\n";
                5: return "L2OFF\015\n";
                6: return "FANON\015\n";
                default: return "FANOFF\015\n";
            endcase
        endfunction

        function void set_mask(logic idx, logic [7:0] value);
            if (idx == GROUP_ONE_REG) begin
                group_one = value;
            end else begin
                group_two = value;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            t_led_status r;
            t_cmd_code   code;
            string       text;
            int          c;
            r    = '0;
            code = CMD_NONE;
            if (b == NEWLINE) begin
                for (c = 0; c < 8; c++) begin
                    text = command_text(c);
                    if (code == CMD_NONE && candidates[c] && int'(position) + 1 == text.len())
                        code = t_cmd_code'(c + 1);
                end
                case (code)
                    CMD_ON: begin
                        pattern = 8'hFF;
                        power   = 1'b1;
                    end
                    CMD_OFF: begin
                        pattern = 8'h00;
                        power   = 1'b0;
                    end
                    CMD_L1ON: begin
                        if (power) pattern = group_one;
                        else r.refused = 1'b1;
                    end
                    CMD_L1OFF: pattern = pattern & ~group_one;
                    CMD_L2ON: begin
                        if (power) pattern = group_two;
                        else r.refused = 1'b1;
                    end
                    CMD_L2OFF: pattern = pattern & ~group_two;
                    CMD_FANON: r.fan = 1'b1;
                    default: ;
                endcase
                r.done     = 1'b1;
                r.code     = code;
                position   = 4'd0;
                candidates = 8'hFF;
            end else begin
                for (c = 0; c < 8; c++) begin
                    text = command_text(c);
                    if (!(int'(position) < text.len() && text[position] == b))
                        candidates[c] = 1'b0;
                end
                if (position != 4'd15) position = position + 4'd1;
            end
            r.led   = pattern;
            r.power = power;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_led_status got);
            t_led_status want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no transaction pending, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("led_pattern", want.led, got.led);
            compare_field("power_on", want.power, got.power);
            compare_field("line_done", want.done, got.done);
            compare_field("command_code", want.code, got.code);
            compare_field("refused_power_off", want.refused, got.refused);
            compare_field("fan_start", want.fan, got.fan);
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_index = GROUP_ONE_REG;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_valid    = 1'b0;
    logic [7:0] i_rx_byte  = 8'h00;
    logic       i_ready    = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_led_pattern;
    logic       o_power_on;
    logic       o_line_done;
    logic [3:0] o_command_code;
    logic       o_refused_power_off;
    logic       o_fan_start;

    t_led_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              bytes_sent = 0;
    int              cycle_count = 0;
    logic [7:0]      line_buf[$];

    serial_line_command_decoder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_led_pattern       (o_led_pattern),
        .o_power_on          (o_power_on),
        .o_line_done         (o_line_done),
        .o_command_code      (o_command_code),
        .o_refused_power_off (o_refused_power_off),
        .o_fan_start         (o_fan_start)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("serial_line_command_decoder: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_led_pattern, o_power_on, o_line_done, o_command_code,
                             o_refused_power_off, o_fan_start});
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic random_line();
        int    kind;
        int    i;
        int    n;
        string s;
        kind = $urandom_range(99);
        line_buf.delete();
        if (kind < 80) begin
            s = t_led_scoreboard::command_text((kind < 15) ? 0 : $urandom_range(7));
            for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
            if (kind >= 65) begin
                i = $urandom_range(s.len() - 2);
                if (kind < 73) line_buf[i] = 8'($urandom_range(255));
                else line_buf.delete(i);
            end
        end else begin
            n = $urandom_range(20);
            for (i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(255)));
            line_buf.push_back(NEWLINE);
        end
        foreach (line_buf[k]) send_byte(line_buf[k]);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_masks(input logic [7:0] one, input logic [7:0] two);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= GROUP_ONE_REG;
        i_cfg_data  <= one;
        @(posedge i_clk);
        sb.set_mask(GROUP_ONE_REG, one);
        i_cfg_index <= GROUP_TWO_REG;
        i_cfg_data  <= two;
        @(posedge i_clk);
        sb.set_mask(GROUP_TWO_REG, two);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int phase;
        int phase_start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 19;
        recv_stall_pct = 70;
        send_text("L1ON\015\n");
        send_text("L2OFF\015\n");
        send_text("ON\015\n");
        send_text("L1ON\015\n");
        send_text("L2ON\015\n");
        send_text("L1OFF\015\n");
        send_text("L2OFF\015\n");
        send_text("FANON\015\n");
        send_text("FANOFF\015\n");
        send_text("OFF\015\n");
        send_text("L2ON\015\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(NEWLINE);
        send_text("ONONONONONONONONON\015\n");
        send_byte(NEWLINE);

        for (phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: write_masks(8'h00, 8'hFF);
                1: write_masks(8'hFF, 8'h00);
                default: write_masks(8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            send_idle_pct  = (phase == 0) ? 19 : (phase == 1) ? 70 : 0;
            recv_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 19 : 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_line();
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("serial_line_command_decoder: match");
        end else begin
            $display("serial_line_command_decoder: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/sld_pkg.sv
hdl/sld_match.sv
hdl/sld_exec.sv
hdl/serial_line_command_decoder.sv
test/tb_serial_line_command_decoder.sv
